@@ hw/rtl/vnfbm_pkg.sv @@
`timescale 1ns / 1ps

package vnfbm_pkg;

    // Default sizes of the generator
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int COORD_BITS_DEF  = 12;

    // Sample coordinate: 32 integer bits over 16 fractional bits
    localparam int FRAC_W = 16;
    localparam int SC_W   = 48;

    // Datapath widths inside an octave cell
    localparam int LVL_W  = 33;   // lattice level, signed Q1.30 with headroom
    localparam int DIF_W  = 34;   // difference of two levels
    localparam int BL_W   = 34;   // blended level
    localparam int ACC_W  = 50;   // weighted octave sum, scaled by 2^46
    localparam int CELL_LAT = 10; // pipeline stages in one cell

    // Configuration register widths and reset values
    localparam int CFG_W  = 28;
    localparam int OCT_W  = 4;
    localparam int FREQ_W = 16;
    localparam int OFS_W  = 28;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd3932;

    // Integer hash constants
    localparam logic [31:0] HASH_ROW   = 32'd57;
    localparam logic [31:0] HASH_A     = 32'd15731;
    localparam logic [31:0] HASH_B     = 32'd789221;
    localparam logic [31:0] HASH_C     = 32'd1376312589;
    localparam logic [31:0] LEVEL_ONE  = 32'h4000_0000;

    // Output mapping
    localparam int OUT_W      = 16;
    localparam int OUT_SHIFT  = 31;
    localparam int HALF_SHIFT = 46;

    typedef enum logic [1:0] {
        REG_OCTAVE_COUNT = 2'd0,
        REG_FREQ_STEP    = 2'd1,
        REG_OFFSET_X     = 2'd2,
        REG_OFFSET_Y     = 2'd3
    } cfg_reg_t;

    // First hash steps: combine the cell indices and mix in the shifted copy.
    function automatic logic [31:0] hash_seed(input logic [31:0] cx, input logic [31:0] cy);
        logic [31:0] n;
        n = cx + cy * HASH_ROW;
        return (n << 13) ^ n;
    endfunction

    // Turn the finished hash into a signed level of one minus its low 31 bits.
    function automatic logic signed [LVL_W-1:0] level_of(input logic [31:0] p);
        return $signed({1'b0, LEVEL_ONE}) - $signed({2'b00, p[30:0]});
    endfunction

endpackage

@@ hw/rtl/value_noise_fbm_generator_unit.sv @@
`timescale 1ns / 1ps

// Fractal value-noise generator. One pixel coordinate pair enters per transfer and one
// 16-bit noise level leaves per transfer, in order; a new pixel can be taken on every
// clock unless a finished level waits at the output, which holds the whole pipeline.
// A register scales the coordinate; a row of MAX_OCTAVES octave cells, each a ten-stage
// hash and blend pipeline, adds its octave (cells beyond the clipped octave count
// pass the sum unchanged); a final register maps and saturates the level. The user
// writes configuration only while no pixel is in flight; the block does not enforce it.
module value_noise_fbm_generator_unit #(
    parameter int MAX_OCTAVES = vnfbm_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_BITS  = vnfbm_pkg::COORD_BITS_DEF,
    parameter int IN_TD_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [vnfbm_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_TD_W-1:0]          s_tdata,   // pixel_x, pixel_y
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [vnfbm_pkg::OUT_W-1:0] m_tdata    // noise_level
);
    import vnfbm_pkg::*;

    localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

    cfg_reg_t cfg_sel;
    logic [OCT_W-1:0]  oct_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [OFS_W-1:0]  offx_reg, offy_reg;
    logic [CNT_W-1:0]  cnt_eff;

    logic en;
    logic f_vld_reg;
    logic [SC_W-1:0] f_sx_reg, f_sy_reg;
    logic [COORD_BITS-1:0] px, py;

    logic                    vld_c [MAX_OCTAVES+1];
    logic [SC_W-1:0]         sx_c  [MAX_OCTAVES+1];
    logic [SC_W-1:0]         sy_c  [MAX_OCTAVES+1];
    logic signed [ACC_W-1:0] acc_c [MAX_OCTAVES+1];

    logic signed [ACC_W:0] biased;
    logic signed [ACC_W-OUT_SHIFT:0] lvl;
    logic [OUT_W-1:0] lvl_sat;
    logic out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    // Configuration writes
    assign cfg_sel = cfg_reg_t'(cfg_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg  <= OCT_RESET;
            freq_reg <= FREQ_RESET;
            offx_reg <= '0;
            offy_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_OCTAVE_COUNT: oct_reg  <= cfg_wdata[OCT_W-1:0];
                REG_FREQ_STEP:    freq_reg <= cfg_wdata[FREQ_W-1:0];
                REG_OFFSET_X:     offx_reg <= cfg_wdata[OFS_W-1:0];
                REG_OFFSET_Y:     offy_reg <= cfg_wdata[OFS_W-1:0];
                default:          oct_reg  <= oct_reg;
            endcase
        end
    end

    // Octave count clipped to one and to the number of cells.
    always_comb
    begin
        if (oct_reg == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (int'(oct_reg) > MAX_OCTAVES)
        begin
            cnt_eff = CNT_W'(MAX_OCTAVES);
        end
        else
        begin
            cnt_eff = CNT_W'(oct_reg);
        end
    end

    // The whole pipeline moves unless a level waits at the output.
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Scale the pixel position into the sample coordinate.
    assign px = s_tdata[COORD_BITS-1:0];
    assign py = s_tdata[2*COORD_BITS-1:COORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sx_reg <= SC_W'(px) * SC_W'(freq_reg) + SC_W'(offx_reg);
            f_sy_reg <= SC_W'(py) * SC_W'(freq_reg) + SC_W'(offy_reg);
        end
    end

    // Row of octave cells
    assign vld_c[0] = f_vld_reg;
    assign sx_c[0]  = f_sx_reg;
    assign sy_c[0]  = f_sy_reg;
    assign acc_c[0] = '0;

    for (genvar g = 0; g < MAX_OCTAVES; g++)
    begin : g_cell
        vnfbm_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .active  (CNT_W'(g) < cnt_eff),
            .vld_in  (vld_c[g]),
            .sx_in   (sx_c[g]),
            .sy_in   (sy_c[g]),
            .acc_in  (acc_c[g]),
            .vld_out (vld_c[g+1]),
            .sx_out  (sx_c[g+1]),
            .sy_out  (sy_c[g+1]),
            .acc_out (acc_c[g+1])
        );
    end

    // Map the sum from -1..1 to 0..65535 and saturate.
    always_comb
    begin
        biased = (ACC_W+1)'(acc_c[MAX_OCTAVES]) + ((ACC_W+1)'(1) <<< HALF_SHIFT);
        lvl    = biased[ACC_W:OUT_SHIFT];
        if (lvl < 0)
        begin
            lvl_sat = '0;
        end
        else if (lvl > $signed((ACC_W-OUT_SHIFT+1)'(16'hFFFF)))
        begin
            lvl_sat = '1;
        end
        else
        begin
            lvl_sat = lvl[OUT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_c[MAX_OCTAVES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= lvl_sat;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hw/rtl/vnfbm_cell.sv @@
`timescale 1ns / 1ps

module vnfbm_cell #(
    parameter int IDX = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   active,
    input  logic                                   vld_in,
    input  logic [vnfbm_pkg::SC_W-1:0]             sx_in,
    input  logic [vnfbm_pkg::SC_W-1:0]             sy_in,
    input  logic signed [vnfbm_pkg::ACC_W-1:0]     acc_in,
    output logic                                   vld_out,
    output logic [vnfbm_pkg::SC_W-1:0]             sx_out,
    output logic [vnfbm_pkg::SC_W-1:0]             sy_out,
    output logic signed [vnfbm_pkg::ACC_W-1:0]     acc_out
);
    import vnfbm_pkg::*;

    localparam int SH = 15 - IDX;

    // Pass-through lines for the item travelling beside the datapath
    logic                    vld_pipe_reg [CELL_LAT];
    logic [SC_W-1:0]         sx_pipe_reg  [CELL_LAT];
    logic [SC_W-1:0]         sy_pipe_reg  [CELL_LAT];
    logic signed [ACC_W-1:0] acc_pipe_reg [CELL_LAT-1];
    logic signed [ACC_W-1:0] acc_out_reg, acc_out_next;

    // Stage 0
    logic [31:0] cx, cy, cx1, cy1;
    logic [31:0] n1_next [4];
    logic [31:0] n1_reg  [4];
    logic [FRAC_W-1:0] fx_reg, fy_reg;
    logic [31:0] ffx_reg, ffy_reg;
    // Stage 1
    logic [31:0] sq_reg [4];
    logic [31:0] n1a_reg [4];
    logic [17:0] gx, gy;
    logic [49:0] tx, ty;
    logic [FRAC_W-1:0] ux1_reg, vy1_reg;
    // Stage 2
    logic [31:0] m_reg [4];
    logic [31:0] n1b_reg [4];
    logic [FRAC_W-1:0] ux2_reg, vy2_reg;
    // Stage 3
    logic [31:0] p_reg [4];
    logic [FRAC_W-1:0] ux3_reg, vy3_reg;
    // Stage 4
    logic signed [LVL_W-1:0] la_next, lb_next, lc_next, ld_next;
    logic signed [LVL_W-1:0] la4_reg, lc4_reg;
    logic signed [DIF_W-1:0] dab_reg, dcd_reg;
    logic [FRAC_W-1:0] ux4_reg, vy4_reg;
    // Stage 5
    logic signed [50:0] pab_reg, pcd_reg;
    logic signed [LVL_W-1:0] la5_reg, lc5_reg;
    logic [FRAC_W-1:0] vy5_reg;
    // Stage 6
    logic signed [BL_W-1:0] r0_reg, r1_reg;
    logic [FRAC_W-1:0] vy6_reg;
    // Stage 7
    logic signed [BL_W:0] dy_reg;
    logic signed [BL_W-1:0] r07_reg;
    logic [FRAC_W-1:0] vy7_reg;
    // Stage 8
    logic signed [51:0] py_reg;
    logic signed [BL_W-1:0] r08_reg;
    // Stage 9
    logic signed [BL_W-1:0] noise;
    logic signed [ACC_W-1:0] weighted;

    // Lattice corners and the first hash steps for all four of them.
    always_comb
    begin
        cx  = sx_in[FRAC_W +: 32];
        cy  = sy_in[FRAC_W +: 32];
        cx1 = cx + 32'd1;
        cy1 = cy + 32'd1;
        n1_next[0] = hash_seed(cx,  cy);
        n1_next[1] = hash_seed(cx1, cy);
        n1_next[2] = hash_seed(cx,  cy1);
        n1_next[3] = hash_seed(cx1, cy1);
    end

    // Fade terms: 3*2^16 - 2f, then the product with f*f.
    always_comb
    begin
        gx = 18'd196608 - {1'b0, fx_reg, 1'b0};
        gy = 18'd196608 - {1'b0, fy_reg, 1'b0};
        tx = {18'd0, ffx_reg} * {32'd0, gx};
        ty = {18'd0, ffy_reg} * {32'd0, gy};
    end

    // Corner levels; their row differences are registered in stage 4.
    always_comb
    begin
        la_next = level_of(p_reg[0]);
        lb_next = level_of(p_reg[1]);
        lc_next = level_of(p_reg[2]);
        ld_next = level_of(p_reg[3]);
    end

    // Last blend and the weighted contribution of this octave.
    always_comb
    begin
        noise        = BL_W'(r08_reg + BL_W'(py_reg >>> FRAC_W));
        weighted     = ACC_W'(noise) <<< SH;
        acc_out_next = active ? (acc_pipe_reg[CELL_LAT-2] + weighted)
                              : acc_pipe_reg[CELL_LAT-2];
    end

    // Valid line, the only state here that needs a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELL_LAT; k++)
            begin
                vld_pipe_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_pipe_reg[0] <= vld_in;
            for (int k = 1; k < CELL_LAT; k++)
            begin
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
            end
        end
    end

    // Coordinate and sum lines.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_pipe_reg[0]  <= sx_in;
            sy_pipe_reg[0]  <= sy_in;
            acc_pipe_reg[0] <= acc_in;
            for (int k = 1; k < CELL_LAT; k++)
            begin
                sx_pipe_reg[k] <= sx_pipe_reg[k-1];
                sy_pipe_reg[k] <= sy_pipe_reg[k-1];
            end
            for (int k = 1; k < CELL_LAT - 1; k++)
            begin
                acc_pipe_reg[k] <= acc_pipe_reg[k-1];
            end
            acc_out_reg <= acc_out_next;
        end
    end

    // Hash and blend datapath, at most one multiplier per path per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                n1_reg[c]  <= n1_next[c];
                sq_reg[c]  <= n1_reg[c] * n1_reg[c];
                n1a_reg[c] <= n1_reg[c];
                m_reg[c]   <= sq_reg[c] * HASH_A + HASH_B;
                n1b_reg[c] <= n1a_reg[c];
                p_reg[c]   <= n1b_reg[c] * m_reg[c] + HASH_C;
            end
            fx_reg  <= sx_in[FRAC_W-1:0];
            fy_reg  <= sy_in[FRAC_W-1:0];
            ffx_reg <= {16'd0, sx_in[FRAC_W-1:0]} * {16'd0, sx_in[FRAC_W-1:0]};
            ffy_reg <= {16'd0, sy_in[FRAC_W-1:0]} * {16'd0, sy_in[FRAC_W-1:0]};
            ux1_reg <= tx[47:32];
            vy1_reg <= ty[47:32];
            ux2_reg <= ux1_reg;
            vy2_reg <= vy1_reg;
            ux3_reg <= ux2_reg;
            vy3_reg <= vy2_reg;
            la4_reg <= la_next;
            lc4_reg <= lc_next;
            dab_reg <= DIF_W'(lb_next) - DIF_W'(la_next);
            dcd_reg <= DIF_W'(ld_next) - DIF_W'(lc_next);
            ux4_reg <= ux3_reg;
            vy4_reg <= vy3_reg;
            pab_reg <= dab_reg * $signed({1'b0, ux4_reg});
            pcd_reg <= dcd_reg * $signed({1'b0, ux4_reg});
            la5_reg <= la4_reg;
            lc5_reg <= lc4_reg;
            vy5_reg <= vy4_reg;
            r0_reg  <= BL_W'(BL_W'(la5_reg) + BL_W'(pab_reg >>> FRAC_W));
            r1_reg  <= BL_W'(BL_W'(lc5_reg) + BL_W'(pcd_reg >>> FRAC_W));
            vy6_reg <= vy5_reg;
            dy_reg  <= (BL_W+1)'(r1_reg) - (BL_W+1)'(r0_reg);
            r07_reg <= r0_reg;
            vy7_reg <= vy6_reg;
            py_reg  <= dy_reg * $signed({1'b0, vy7_reg});
            r08_reg <= r07_reg;
        end
    end

    // The next octave samples at twice the coordinate.
    assign vld_out = vld_pipe_reg[CELL_LAT-1];
    assign sx_out  = sx_pipe_reg[CELL_LAT-1] << 1;
    assign sy_out  = sy_pipe_reg[CELL_LAT-1] << 1;
    assign acc_out = acc_out_reg;

endmodule

@@ hw/rtl/vnfbm_chk.sv @@
`timescale 1ns / 1ps

module vnfbm_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [vnfbm_pkg::OUT_W-1:0] m_tdata
);
    // A level offered but not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled level keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // The input side is held back only by a waiting level.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output occupancy");

    // A new level appears only if the pipeline moved when it was registered.
    a_new_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("output appeared while pipeline held");

endmodule

bind value_noise_fbm_generator_unit vnfbm_chk u_vnfbm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
